// ===== hw/rtl/hlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hlc_pkg;

    // Default sizes of the history store
    localparam int DEPTH_DEF        = 16;
    localparam int HANDLE_WIDTH_DEF = 32;

    // Fixed field widths of the channels
    localparam int ACTION_W = 3;
    localparam int PAGE_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_VISIT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BACK    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FORWARD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CURRENT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_OPEN    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ    = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OLDEST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEWEST = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/hlc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlc_ram #(
    parameter int DEPTH        = hlc_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = hlc_pkg::HANDLE_WIDTH_DEF,
    localparam int AW          = $clog2(DEPTH)
) (
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire logic [HANDLE_WIDTH-1:0] wr_data,
    input  wire logic                    rd_en,
    input  wire logic [AW-1:0]           rd_addr,
    output logic      [HANDLE_WIDTH-1:0] rd_data
);

    logic [HANDLE_WIDTH-1:0] mem [DEPTH];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/history_list_with_cursor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded page history with a cursor, as kept by a browser's back/forward list.
// Input channel (in_valid/in_stall) carries one action beat: action, page, position.
// Output channel (out_valid/out_stall) returns exactly one result beat per action:
// status, page_out, cursor_out, count_out.
// Handles live in a single-port-write, single-port-read memory with registered read.
// An action beat passes through the EXEC and RESULT states to the output register;
// the block takes the next action only once it is back in IDLE. A remove that moves
// entries also steps through SHIFT for each entry moved down, then FETCH to read the
// current page again, since the one memory read port serves both the shift and the page lookup.
// in_stall is high while an action is in flight. A finished result waits in the
// output register while the receiver stalls; the block still takes the next action
// and holds that one's result until the register frees up.
// Reset empties the list (count and cursor go to zero) and drops any pending result;
// the memory is not cleared, since only entries below count are ever returned.
module history_list_with_cursor #(
    parameter int DEPTH        = hlc_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = hlc_pkg::HANDLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [hlc_pkg::ACTION_W-1:0]  action,
    input  wire logic [hlc_pkg::PAGE_W-1:0]    page,
    input  wire logic [hlc_pkg::POS_W-1:0]     position,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [hlc_pkg::STATUS_W-1:0]  status,
    output logic      [hlc_pkg::PAGE_W-1:0]    page_out,
    output logic      [hlc_pkg::POS_W-1:0]     cursor_out,
    output logic      [hlc_pkg::POS_W-1:0]     count_out
);

    localparam int CURW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int PW   = hlc_pkg::POS_W;
    localparam int PGW  = hlc_pkg::PAGE_W;
    localparam int CMPW = (CNTW > PW) ? CNTW : PW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    // control state
    logic [2:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CURW-1:0] cursor_reg, cursor_next;
    logic            out_valid_reg, out_valid_next;

    // payload state
    logic [hlc_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [HANDLE_WIDTH-1:0]      page_reg, page_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [hlc_pkg::STATUS_W-1:0] st_reg, st_next;
    logic                         zero_reg, zero_next;
    logic                         direct_reg, direct_next;
    logic [CURW-1:0]              ptr_reg, ptr_next;
    logic [hlc_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PGW-1:0]               out_page_reg, out_page_next;
    logic [PW-1:0]                out_cursor_reg, out_cursor_next;
    logic [PW-1:0]                out_count_reg, out_count_next;

    // memory port
    logic                    wr_en;
    logic [CURW-1:0]         wr_addr;
    logic [HANDLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [CURW-1:0]         rd_addr;
    logic [HANDLE_WIDTH-1:0] rd_data;

    // action decode
    logic [CMPW-1:0]              pos_w;
    logic                         idx_ok;
    logic [CURW-1:0]              idx;
    logic [CNTW-1:0]              idx_p1;
    logic [CNTW-1:0]              cur_p1;
    logic [hlc_pkg::STATUS_W-1:0] x_status;
    logic [CNTW-1:0]              x_count;
    logic [CURW-1:0]              x_cursor;
    logic                         x_zero;
    logic                         x_direct;
    logic                         x_wr;
    logic                         x_shift;
    logic [CURW-1:0]              x_rd_addr;

    logic            in_accept;
    logic            out_free;
    logic [CURW-1:0] ptr_inc;
    logic            shift_more;
    logic [HANDLE_WIDTH-1:0] shown;

    hlc_ram #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pos_w  = CMPW'(pos_reg);
    assign idx_ok = (pos_reg != '0) && (pos_w <= CMPW'(count_reg));
    assign idx    = CURW'(pos_w - CMPW'(1));
    assign idx_p1 = CNTW'(idx) + CNTW'(1);
    assign cur_p1 = CNTW'(cursor_reg) + CNTW'(1);

    // Work out the new list state for the held action
    always_comb
    begin
        x_status  = hlc_pkg::ST_OK;
        x_count   = count_reg;
        x_cursor  = cursor_reg;
        x_zero    = 1'b0;
        x_direct  = 1'b0;
        x_wr      = 1'b0;
        x_shift   = 1'b0;
        x_rd_addr = cursor_reg;
        unique case (act_reg)
            hlc_pkg::ACT_VISIT:
            begin
                if (count_reg != '0 && cur_p1 >= CNTW'(DEPTH))
                begin
                    x_status = hlc_pkg::ST_FULL;
                end
                else
                begin
                    // drop forward entries, append after the cursor
                    x_wr     = 1'b1;
                    x_direct = 1'b1;
                    x_cursor = (count_reg == '0) ? '0 : CURW'(cur_p1);
                    x_count  = (count_reg == '0) ? CNTW'(1) : cur_p1 + CNTW'(1);
                end
            end
            hlc_pkg::ACT_BACK:
            begin
                if (count_reg == '0)
                begin
                    x_status = hlc_pkg::ST_EMPTY;
                end
                else if (cursor_reg == '0)
                begin
                    x_status = hlc_pkg::ST_OLDEST;
                end
                else
                begin
                    x_cursor = cursor_reg - CURW'(1);
                end
            end
            hlc_pkg::ACT_FORWARD:
            begin
                if (count_reg == '0)
                begin
                    x_status = hlc_pkg::ST_EMPTY;
                end
                else if (cur_p1 >= count_reg)
                begin
                    x_status = hlc_pkg::ST_NEWEST;
                end
                else
                begin
                    x_cursor = CURW'(cur_p1);
                end
            end
            hlc_pkg::ACT_CURRENT:
            begin
                if (count_reg == '0)
                begin
                    x_status = hlc_pkg::ST_EMPTY;
                end
            end
            hlc_pkg::ACT_OPEN:
            begin
                if (!idx_ok)
                begin
                    x_status = hlc_pkg::ST_BADIDX;
                end
                else
                begin
                    x_cursor = idx;
                end
            end
            hlc_pkg::ACT_REMOVE:
            begin
                if (!idx_ok)
                begin
                    x_status = hlc_pkg::ST_BADIDX;
                end
                else
                begin
                    if (cursor_reg == idx)
                    begin
                        if (idx_p1 < count_reg)
                        begin
                            x_cursor = idx;
                        end
                        else if (idx != '0)
                        begin
                            x_cursor = idx - CURW'(1);
                        end
                        else
                        begin
                            x_cursor = '0;
                        end
                    end
                    else if (cursor_reg > idx)
                    begin
                        x_cursor = cursor_reg - CURW'(1);
                    end
                    x_count = count_reg - CNTW'(1);
                    if (x_count == '0)
                    begin
                        x_cursor = '0;
                    end
                    // later entries move down one slot each
                    x_shift = (idx_p1 < count_reg);
                end
            end
            hlc_pkg::ACT_READ:
            begin
                if (!idx_ok)
                begin
                    x_status = hlc_pkg::ST_BADIDX;
                end
            end
            hlc_pkg::ACT_CLEAR:
            begin
                x_count  = '0;
                x_cursor = '0;
            end
            default:
            begin
                x_status = hlc_pkg::ST_OK;
            end
        endcase

        if (act_reg == hlc_pkg::ACT_READ)
        begin
            x_zero    = !idx_ok;
            x_rd_addr = idx;
        end
        else
        begin
            x_zero    = (x_count == '0);
            x_rd_addr = x_shift ? CURW'(idx_p1) : x_cursor;
        end
    end

    assign ptr_inc    = ptr_reg + CURW'(1);
    assign shift_more = (CNTW'(ptr_reg) + CNTW'(1)) < count_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = cursor_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                wr_en   = x_wr;
                wr_addr = x_cursor;
                wr_data = page_reg;
                rd_en   = 1'b1;
                rd_addr = x_rd_addr;
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                rd_en   = shift_more;
                rd_addr = ptr_inc + CURW'(1);
            end
            S_FETCH:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign shown = zero_reg ? '0 : (direct_reg ? page_reg : rd_data);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        out_valid_next  = out_valid_reg && out_stall;
        act_next        = act_reg;
        page_next       = page_reg;
        pos_next        = pos_reg;
        st_next         = st_reg;
        zero_next       = zero_reg;
        direct_next     = direct_reg;
        ptr_next        = ptr_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_cursor_next = out_cursor_reg;
        out_count_next  = out_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    act_next   = action;
                    page_next  = HANDLE_WIDTH'(page);
                    pos_next   = position;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                count_next  = x_count;
                cursor_next = x_cursor;
                st_next     = x_status;
                zero_next   = x_zero;
                direct_next = x_direct;
                ptr_next    = idx;
                state_next  = x_shift ? S_SHIFT : S_RESULT;
            end
            S_SHIFT:
            begin
                ptr_next = ptr_inc;
                if (!shift_more)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_page_next   = PGW'(shown);
                    out_cursor_next = (count_reg == '0) ? '0 : PW'(CNTW'(cursor_reg) + CNTW'(1));
                    out_count_next  = PW'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        page_reg       <= page_next;
        pos_reg        <= pos_next;
        st_reg         <= st_next;
        zero_reg       <= zero_next;
        direct_reg     <= direct_next;
        ptr_reg        <= ptr_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_cursor_reg <= out_cursor_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign page_out   = out_page_reg;
    assign cursor_out = out_cursor_reg;
    assign count_out  = out_count_reg;

endmodule

`default_nettype wire
